[design/base64_stream_decoder_core_defines.svh]
// ----------------------------------------------------------------------------
// base64 stream decoder assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_DECODER_CORE_DEFINES_SVH
`define BASE64_STREAM_DECODER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define B64D_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("b64d same-cycle check failed");

// next-cycle implication, checked outside reset
`define B64D_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("b64d next-cycle check failed");

`endif

[design/b64d_pkg.sv]
// ----------------------------------------------------------------------------
// b64d_pkg
// Types, status codes and the character map of the base64 stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64d_pkg;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_BAD_SYMBOL = 2'd1,
        STATUS_BAD_LENGTH = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        status_t    status;
        logic       message_done;
    } result_t;

    typedef struct packed {
        logic       ok;
        logic [5:0] value;
    } sextet_t;

    // result queue depth, must hold at least one full group of three beats
    localparam int QUEUE_DEPTH = 6;

    function automatic sextet_t map_symbol(input logic [7:0] ch);
        sextet_t s;
        s.ok    = 1'b1;
        s.value = 6'd0;
        // 'A'..'Z', 'a'..'z', '0'..'9', '+', '/'
        if (ch >= 8'h41 && ch <= 8'h5a)
            s.value = 6'(ch - 8'd65);
        else if (ch >= 8'h61 && ch <= 8'h7a)
            s.value = 6'(ch - 8'd71);
        else if (ch >= 8'h30 && ch <= 8'h39)
            s.value = 6'(ch + 8'd4);
        else if (ch == 8'h2b)
            s.value = 6'd62;
        else if (ch == 8'h2f)
            s.value = 6'd63;
        else
            s.ok = 1'b0;
        return s;
    endfunction

endpackage

`default_nettype wire

[design/b64d_if.sv]
// ----------------------------------------------------------------------------
// b64d channel interfaces
// Valid/ready channels for input characters and decoded result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface b64d_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       end_of_text;

    modport source (output valid, output symbol, output end_of_text, input ready);
    modport sink   (input valid, input symbol, input end_of_text, output ready);
endinterface

interface b64d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic [1:0] status;
    logic       message_done;

    modport source (output valid, output data_byte, output byte_valid,
                    output status, output message_done, input ready);
    modport sink   (input valid, input data_byte, input byte_valid,
                    input status, input message_done, output ready);
endinterface

`default_nettype wire

[design/base64_stream_decoder_core.sv]
// ----------------------------------------------------------------------------
// base64_stream_decoder_core
// Decodes one base64 character per beat into byte beats with message status.
// ----------------------------------------------------------------------------
// channel   | dir | payload
// chars     | in  | symbol[7:0], end_of_text
// decoded   | out | data_byte[7:0], byte_valid, status[1:0], message_done
//
// a character is taken every cycle while the result queue has room for three
// beats; the fourth character of a group pushes up to three beats at once
// result beats leave the queue one per cycle while decoded.ready is high
// a stalled output backs up into the queue and then drops chars.ready
// reset clears the group state, the error flag and the queue
`default_nettype none

`include "base64_stream_decoder_core_defines.svh"

module base64_stream_decoder_core #(
    parameter int DEPTH = b64d_pkg::QUEUE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    b64d_char_if.sink        chars,
    b64d_byte_if.source      decoded
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W:0]   DEPTH_W    = (PTR_W + 1)'(DEPTH);
    localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(DEPTH - 3);

    logic [1:0]          group_position_reg, group_position_next;
    logic [5:0]          sextet_first_reg, sextet_first_next;
    logic [5:0]          sextet_second_reg, sextet_second_next;
    logic [5:0]          sextet_third_reg, sextet_third_next;
    logic                third_ok_reg, third_ok_next;
    b64d_pkg::status_t   error_code_reg, error_code_next;

    b64d_pkg::result_t   fifo_mem [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;

    logic                in_fire, out_fire;
    b64d_pkg::sextet_t   sym;
    logic [23:0]         word;
    b64d_pkg::status_t   stat;
    b64d_pkg::result_t   res [3];
    logic [1:0]          push_n;

    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                                  input logic [1:0] k);
        logic [PTR_W:0] s;
        s = {1'b0, p} + (PTR_W + 1)'(k);
        if (s >= DEPTH_W)
            s = s - DEPTH_W;
        return s[PTR_W-1:0];
    endfunction

    assign in_fire  = chars.valid && chars.ready;
    assign out_fire = decoded.valid && decoded.ready;
    assign sym      = b64d_pkg::map_symbol(chars.symbol);
    assign word     = {sextet_first_reg, sextet_second_reg, sextet_third_reg, sym.value};

    assign chars.ready = (count_reg <= ROOM_LIMIT);

    // result beats and next group state for the character on the port
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            res[k] = '{data_byte: 8'd0, byte_valid: 1'b0,
                       status: b64d_pkg::STATUS_OK, message_done: 1'b0};
        end
        push_n = 2'd0;

        group_position_next = group_position_reg + 2'd1;
        sextet_first_next   = sextet_first_reg;
        sextet_second_next  = sextet_second_reg;
        sextet_third_next   = sextet_third_reg;
        third_ok_next       = third_ok_reg;
        error_code_next     = error_code_reg;

        if (error_code_reg == b64d_pkg::STATUS_OK)
        begin
            unique case (group_position_reg)
                2'd0:
                begin
                    if (sym.ok)
                        sextet_first_next = sym.value;
                    else
                        error_code_next = b64d_pkg::STATUS_BAD_SYMBOL;
                end
                2'd1:
                begin
                    if (sym.ok)
                        sextet_second_next = sym.value;
                    else
                        error_code_next = b64d_pkg::STATUS_BAD_SYMBOL;
                end
                2'd2:
                begin
                    sextet_third_next = sym.value;
                    third_ok_next     = sym.ok;
                end
                2'd3:
                begin
                    res[0].data_byte  = word[23:16];
                    res[0].byte_valid = 1'b1;
                    if (third_ok_reg)
                    begin
                        res[1].data_byte  = word[15:8];
                        res[1].byte_valid = 1'b1;
                        res[2].data_byte  = word[7:0];
                        res[2].byte_valid = sym.ok;
                    end
                    else
                    begin
                        res[1].data_byte  = word[7:0];
                        res[1].byte_valid = sym.ok;
                    end
                    push_n = 2'd1 + 2'(third_ok_reg) + 2'(sym.ok);
                end
                default: ;
            endcase
        end

        stat = (group_position_reg == 2'd3) ? error_code_reg
                                            : b64d_pkg::STATUS_BAD_LENGTH;
        if (chars.end_of_text)
        begin
            // an ok status only happens on a decoded fourth char, so push_n > 0
            if (stat == b64d_pkg::STATUS_OK)
            begin
                res[push_n - 2'd1].message_done = 1'b1;
            end
            else
            begin
                res[0] = '{data_byte: 8'd0, byte_valid: 1'b0,
                           status: stat, message_done: 1'b1};
                push_n = 2'd1;
            end
            group_position_next = 2'd0;
            sextet_first_next   = 6'd0;
            sextet_second_next  = 6'd0;
            sextet_third_next   = 6'd0;
            third_ok_next       = 1'b0;
            error_code_next     = b64d_pkg::STATUS_OK;
        end

        if (!in_fire)
            push_n = 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_position_reg <= 2'd0;
            sextet_first_reg   <= 6'd0;
            sextet_second_reg  <= 6'd0;
            sextet_third_reg   <= 6'd0;
            third_ok_reg       <= 1'b0;
            error_code_reg     <= b64d_pkg::STATUS_OK;
        end
        else if (in_fire)
        begin
            group_position_reg <= group_position_next;
            sextet_first_reg   <= sextet_first_next;
            sextet_second_reg  <= sextet_second_next;
            sextet_third_reg   <= sextet_third_next;
            third_ok_reg       <= third_ok_next;
            error_code_reg     <= error_code_next;
        end
    end

    // result queue storage
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (2'(k) < push_n)
                fifo_mem[ptr_add(wr_ptr_reg, 2'(k))] <= res[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= ptr_add(wr_ptr_reg, push_n);
            if (out_fire)
                rd_ptr_reg <= ptr_add(rd_ptr_reg, 2'd1);
            count_reg <= count_reg + CNT_W'(push_n) - CNT_W'(out_fire);
        end
    end

    assign decoded.valid        = (count_reg != '0);
    assign decoded.data_byte    = fifo_mem[rd_ptr_reg].data_byte;
    assign decoded.byte_valid   = fifo_mem[rd_ptr_reg].byte_valid;
    assign decoded.status       = fifo_mem[rd_ptr_reg].status;
    assign decoded.message_done = fifo_mem[rd_ptr_reg].message_done;

    `B64D_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH))
    `B64D_ASSERT_NEXT(a_last_clears_group, clk, rst_n, in_fire && chars.end_of_text,
        group_position_reg == 2'd0 && error_code_reg == b64d_pkg::STATUS_OK)
    `B64D_ASSERT_NEXT(a_group_pushes, clk, rst_n,
        in_fire && group_position_reg == 2'd3 && error_code_reg == b64d_pkg::STATUS_OK,
        count_reg != '0)
    `B64D_ASSERT_NEXT(a_error_sticky, clk, rst_n,
        error_code_reg != b64d_pkg::STATUS_OK && !(in_fire && chars.end_of_text),
        error_code_reg != b64d_pkg::STATUS_OK)

endmodule

`default_nettype wire
